>>> src/lgd_pkg.sv
// ----------------------------------------------------------------------------
// lgd_pkg
// Shared field widths, codes and constants of the 1-d lattice gas block.
// ----------------------------------------------------------------------------
package lgd_pkg;

  localparam int MODE_W = 2;
  localparam int IDX_W  = 7;
  localparam int DENS_W = 18;
  localparam int CELL_W = 19;
  localparam int MASS_W = 26;
  localparam int VAR_W  = 30;
  localparam int WGT_W  = 17;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;

  localparam logic [WGT_W-1:0]  WEIGHT_ONE = 17'd65536;
  localparam logic [WGT_W-1:0]  WEIGHT_RST = 17'd32768;
  localparam int                WGT_SHIFT  = 16;

  localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};
  localparam logic [VAR_W-1:0]  VAR_MAX  = {VAR_W{1'b1}};

endpackage

>>> src/lattice_gas_diffusion_1d.sv
// ----------------------------------------------------------------------------
// lattice_gas_diffusion_1d
// Two-velocity lattice gas on a ring of cells, densities held in two memories.
// ----------------------------------------------------------------------------
// load and mode 3: result registered in the accepting cycle
// read: the memory read is registered, then the sum in the read state
// step: two memory walks, each followed by the bit-serial divider (both divides
//   skipped on an empty ring, which gives an empty report), one item at a time
// reset: a clearing pass zeroes both memories before items are taken
module lattice_gas_diffusion_1d
  import lgd_pkg::*;
#(
  parameter int CELLS     = 128,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              coll_weight_we,
  input  logic [WGT_W-1:0]  coll_weight,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [MODE_W-1:0] mode,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic [DENS_W-1:0] density,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [CELL_W-1:0] cell_density,
  output logic [MASS_W-1:0] total_mass,
  output logic [VAR_W-1:0]  variance,
  output logic              empty_flag
);

  localparam int ADRW  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNTW  = $clog2(CELLS + 7);
  localparam int IXW   = (ADRW > IDX_W) ? ADRW : IDX_W;
  localparam int MW    = CELL_W + ADRW;
  localparam int MASSX = (MW > MASS_W) ? MW : MASS_W;
  localparam int S1W   = 2 * ADRW + CELL_W;
  localparam int DW    = ADRW + FRAC_BITS;
  localparam int SQ_K  = (FRAC_BITS + 32) / 2;
  localparam int KX    = (DW > SQ_K) ? DW : SQ_K;
  localparam int SQW   = 2 * SQ_K;
  localparam int PRW   = VAR_W + CELL_W;
  localparam int ACCW  = PRW + ADRW;
  localparam int DVW   = ((S1W + FRAC_BITS) > ACCW) ? (S1W + FRAC_BITS) : ACCW;
  localparam int DCW   = $clog2(DVW + 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_P1   = 3'd3;
  localparam logic [2:0] ST_DIV1 = 3'd4;
  localparam logic [2:0] ST_P2   = 3'd5;
  localparam logic [2:0] ST_DIV2 = 3'd6;

  logic [DENS_W-1:0] right_mem [CELLS];
  logic [DENS_W-1:0] left_mem  [CELLS];

  logic [2:0]        state;
  logic [CNTW-1:0]   cnt;
  logic [WGT_W-1:0]  weight;
  logic              rd_ok;

  logic              item_acc;
  logic              issue;
  logic [IXW-1:0]    idx_x;
  logic              idx_ok;
  logic [ADRW-1:0]   raddr;
  logic [DENS_W-1:0] r_q, l_q;

  logic              we_r, we_l;
  logic [ADRW-1:0]   wa_r, wa_l;
  logic [DENS_W-1:0] wd_r, wd_l;

  logic              v0, v1, v2, v3, v4, fix;
  logic [ADRW-1:0]   c0;
  logic [CELL_W-1:0] rho0, rho1, rho2, rho3;
  logic [ADRW+CELL_W-1:0] mp1;
  logic [SQ_K-1:0]   dcl1;
  logic [SQW-1:0]    sq2;
  logic [VAR_W-1:0]  sqc3;
  logic [PRW-1:0]    prod4;

  logic [MW-1:0]     mass;
  logic [S1W-1:0]    s1;
  logic [ACCW-1:0]   acc;
  logic [DW-1:0]     mean;

  logic [DW-1:0]     pos, dev;
  logic [KX-1:0]     dev_x;
  logic [SQW-FRAC_BITS-1:0] sq_s;

  logic [WGT_W-1:0]  w_eff;
  logic signed [CELL_W-1:0] diff;
  logic signed [36:0] mix;
  logic signed [36:0] mix_s;
  logic signed [19:0] nr20;
  logic [DENS_W-1:0] nr, nl, nr_prev, nl_first;
  logic [CELL_W-1:0] sum_rl, nl19;

  logic [DVW-1:0]    dq, dq_next;
  logic [MW-1:0]     drem, drem_next;
  logic [MW:0]       trial;
  logic              qbit;
  logic [DCW-1:0]    dcnt;
  logic              div_last;

  logic [MASSX-1:0]  mass_x;
  logic [MASS_W-1:0] mass_sat;

  assign item_stall = (state != ST_IDLE) || (result_valid && result_stall);
  assign item_acc   = item_valid && !item_stall;
  assign idx_x      = IXW'(cell_index);
  assign idx_ok     = {1'b0, idx_x} < (IXW+1)'(CELLS);
  assign issue      = ((state == ST_P1) || (state == ST_P2)) && (cnt < CNTW'(CELLS));
  assign raddr      = issue ? cnt[ADRW-1:0] : idx_x[ADRW-1:0];
  assign rho0       = CELL_W'(r_q) + CELL_W'(l_q);

  // collision: nr = l + floor(w*(r-l)/2^16)
  assign w_eff  = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
  assign diff   = $signed({1'b0, r_q}) - $signed({1'b0, l_q});
  assign mix    = 37'($signed({1'b0, w_eff})) * 37'(diff);
  assign mix_s  = mix >>> WGT_SHIFT;
  assign nr20   = $signed({2'b00, l_q}) + mix_s[19:0];
  assign nr     = nr20[DENS_W-1:0];
  assign sum_rl = CELL_W'(r_q) + CELL_W'(l_q);
  assign nl19   = sum_rl - CELL_W'(nr);
  assign nl     = nl19[DENS_W-1:0];

  // distance of the cell from the mean, clamped where its square caps anyway
  assign pos   = {c0, {FRAC_BITS{1'b0}}};
  assign dev   = (pos >= mean) ? (pos - mean) : (mean - pos);
  assign dev_x = KX'(dev);
  assign sq_s  = sq2[SQW-1:FRAC_BITS];

  // restoring divider by the mass, one quotient bit per cycle
  assign trial     = {drem, dq[DVW-1]};
  assign qbit      = trial >= (MW+1)'(mass);
  assign drem_next = qbit ? MW'(trial - (MW+1)'(mass)) : trial[MW-1:0];
  assign dq_next   = {dq[DVW-2:0], qbit};
  assign div_last  = dcnt == DCW'(DVW - 1);

  assign mass_x   = MASSX'(mass);
  assign mass_sat = (mass_x > MASSX'(MASS_MAX)) ? MASS_MAX : mass_x[MASS_W-1:0];

  always_comb begin
    we_r = 1'b0;
    we_l = 1'b0;
    wa_r = cnt[ADRW-1:0];
    wa_l = cnt[ADRW-1:0];
    wd_r = '0;
    wd_l = '0;
    if (state == ST_CLR) begin
      we_r = 1'b1;
      we_l = 1'b1;
    end else if (item_acc && (mode == MODE_LOAD) && idx_ok) begin
      we_r = 1'b1;
      we_l = 1'b1;
      wa_r = idx_x[ADRW-1:0];
      wa_l = idx_x[ADRW-1:0];
      wd_r = density;
      wd_l = density;
    end else if (state == ST_P2 && v0 && c0 != '0) begin
      we_r = 1'b1;
      we_l = 1'b1;
      wa_r = c0;
      wa_l = c0 - ADRW'(1);
      wd_r = nr_prev;
      wd_l = nl;
    end else if (state == ST_P2 && fix) begin
      we_r = 1'b1;
      we_l = 1'b1;
      wa_r = '0;
      wa_l = ADRW'(CELLS - 1);
      wd_r = nr_prev;
      wd_l = nl_first;
    end
  end

  always_ff @(posedge clk) begin
    if (we_r) begin
      right_mem[wa_r] <= wd_r;
    end
    r_q <= right_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_l) begin
      left_mem[wa_l] <= wd_l;
    end
    l_q <= left_mem[raddr];
  end

  // walk pipeline payload
  always_ff @(posedge clk) begin
    c0    <= raddr;
    rho1  <= rho0;
    mp1   <= (ADRW+CELL_W)'(c0) * (ADRW+CELL_W)'(rho0);
    dcl1  <= (|(dev_x >> SQ_K)) ? {SQ_K{1'b1}} : dev_x[SQ_K-1:0];
    rho2  <= rho1;
    sq2   <= SQW'(dcl1) * SQW'(dcl1);
    rho3  <= rho2;
    sqc3  <= (sq_s > (SQW-FRAC_BITS)'(VAR_MAX)) ? VAR_MAX : sq_s[VAR_W-1:0];
    prod4 <= PRW'(sqc3) * PRW'(rho3);
    if (state == ST_P2 && v0) begin
      nr_prev <= nr;
      if (c0 == '0) begin
        nl_first <= nl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      fix <= 1'b0;
    end else begin
      v0  <= issue;
      v1  <= v0;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      fix <= (state == ST_P2) && v0 && (c0 == ADRW'(CELLS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLR;
      cnt          <= '0;
      weight       <= WEIGHT_RST;
      rd_ok        <= 1'b0;
      dcnt         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (coll_weight_we) begin
        weight <= coll_weight;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(CELLS - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_acc) begin
            cell_density <= '0;
            total_mass   <= '0;
            variance     <= '0;
            empty_flag   <= 1'b0;
            rd_ok        <= idx_ok;
            mass         <= '0;
            s1           <= '0;
            acc          <= '0;
            cnt          <= '0;
            if (mode == MODE_READ) begin
              state <= ST_READ;
            end else if (mode == MODE_STEP) begin
              state <= ST_P1;
            end else begin
              result_valid <= 1'b1;
              if (mode == MODE_LOAD && idx_ok) begin
                cell_density <= {density, 1'b0};
              end
            end
          end
        end
        ST_READ: begin
          cell_density <= rd_ok ? rho0 : '0;
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        ST_P1: begin
          cnt <= cnt + CNTW'(1);
          if (v1) begin
            mass <= mass + MW'(rho1);
            s1   <= s1 + S1W'(mp1);
          end
          if (cnt == CNTW'(CELLS + 5)) begin
            cnt  <= '0;
            mean <= '0;
            dq   <= DVW'(s1) << FRAC_BITS;
            drem <= '0;
            dcnt <= '0;
            state <= (mass == '0) ? ST_P2 : ST_DIV1;
          end
        end
        ST_DIV1: begin
          dq   <= dq_next;
          drem <= drem_next;
          dcnt <= dcnt + DCW'(1);
          if (div_last) begin
            mean  <= dq_next[DW-1:0];
            state <= ST_P2;
          end
        end
        ST_P2: begin
          cnt <= cnt + CNTW'(1);
          if (v4) begin
            acc <= acc + ACCW'(prod4);
          end
          if (cnt == CNTW'(CELLS + 5)) begin
            cnt  <= '0;
            dq   <= DVW'(acc);
            drem <= '0;
            dcnt <= '0;
            if (mass == '0) begin
              empty_flag   <= 1'b1;
              result_valid <= 1'b1;
              state        <= ST_IDLE;
            end else begin
              state <= ST_DIV2;
            end
          end
        end
        ST_DIV2: begin
          dq   <= dq_next;
          drem <= drem_next;
          dcnt <= dcnt + DCW'(1);
          if (div_last) begin
            total_mass   <= mass_sat;
            variance     <= (|dq_next[DVW-1:VAR_W]) ? VAR_MAX : dq_next[VAR_W-1:0];
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/lgd_chk.sv
// ----------------------------------------------------------------------------
// lgd_chk
// Port-level checks of the lattice gas block, bound to the top level.
// ----------------------------------------------------------------------------
module lgd_chk
  import lgd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input logic [CELL_W-1:0] cell_density,
  input logic [MASS_W-1:0] total_mass,
  input logic [VAR_W-1:0]  variance,
  input logic              empty_flag
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(cell_density)
      && $stable(total_mass) && $stable(variance) && $stable(empty_flag))
    else $error("stalled result item changed");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && empty_flag |-> total_mass == '0 && variance == '0
      && cell_density == '0)
    else $error("empty report with nonzero fields");

  a_cell_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && cell_density != '0 |-> total_mass == '0 && variance == '0
      && !empty_flag)
    else $error("cell item carries report fields");

  a_var_mass: assert property (@(posedge clk) disable iff (rst)
    result_valid && total_mass == '0 |-> variance == '0)
    else $error("variance without mass");

endmodule

bind lattice_gas_diffusion_1d lgd_chk u_lgd_chk (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// lattice gas diffusion testbench
// Drives load, step, read and unused-mode items into the ring with random idling on both
// sides, predicts every result from a local copy of both density stores and
// the collision weight, and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import lgd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCELLS = 128;
  localparam int FBITS  = 16;
  localparam int LIMIT  = 5000000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    logic [DENS_W-1:0] dens;
  } lattice_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] dens_sum;
    logic [MASS_W-1:0] mass;
    logic [VAR_W-1:0]  var_q;
    logic              empty;
  } lattice_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic coll_weight_we = 1'b0;
  logic [WGT_W-1:0] coll_weight = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [IDX_W-1:0] cell_index = '0;
  logic [DENS_W-1:0] density = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [CELL_W-1:0] cell_density;
  logic [MASS_W-1:0] total_mass;
  logic [VAR_W-1:0] variance;
  logic empty_flag;

  lattice_item_t   pending_items[$];
  lattice_result_t expected_results[$];
  logic [DENS_W-1:0] model_right[NCELLS];
  logic [DENS_W-1:0] model_left[NCELLS];
  logic [WGT_W-1:0]  model_weight;
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  bit hold_send = 1'b0;

  lattice_gas_diffusion_1d dut (
    .clk(clk), .rst(rst),
    .coll_weight_we(coll_weight_we), .coll_weight(coll_weight),
    .item_valid(item_valid), .item_stall(item_stall),
    .mode(mode), .cell_index(cell_index), .density(density),
    .result_valid(result_valid), .result_stall(result_stall),
    .cell_density(cell_density), .total_mass(total_mass),
    .variance(variance), .empty_flag(empty_flag)
  );

  initial forever #1 clk = ~clk;

  function automatic logic [63:0] sq_dev(logic [63:0] d);
    logic [63:0] h, l, sq;
    h = d >> FBITS;
    l = d & ((64'd1 << FBITS) - 1);
    sq = ((h * h) << FBITS) + 2 * h * l + ((l * l) >> FBITS);
    return (sq > VAR_MAX) ? 64'(VAR_MAX) : sq;
  endfunction

  function automatic lattice_result_t predict_lattice(lattice_item_t it);
    lattice_result_t r;
    logic [63:0] mass, s1, q, rem, mean, acc, pos, d, v, rho, w, rr, ll, nr;
    logic [DENS_W-1:0] nright[NCELLS];
    logic [DENS_W-1:0] nleft[NCELLS];
    r = '0;
    if (it.mode == MODE_LOAD) begin
      model_right[it.idx] = it.dens;
      model_left[it.idx] = it.dens;
      r.dens_sum = CELL_W'(64'(model_right[it.idx]) + model_left[it.idx]);
    end else if (it.mode == MODE_READ) begin
      r.dens_sum = CELL_W'(64'(model_right[it.idx]) + model_left[it.idx]);
    end else if (it.mode == MODE_STEP) begin
      w = (model_weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(model_weight);
      mass = 0;
      s1 = 0;
      for (int c = 0; c < NCELLS; c++) begin
        rho = 64'(model_right[c]) + model_left[c];
        mass += rho;
        s1 += 64'(c) * rho;
      end
      if (mass == 0) begin
        r.empty = 1'b1;
      end else begin
        q = s1 / mass;
        rem = s1 % mass;
        mean = (q << FBITS) + ((rem << FBITS) / mass);
        acc = 0;
        for (int c = 0; c < NCELLS; c++) begin
          pos = 64'(c) << FBITS;
          d = (pos >= mean) ? pos - mean : mean - pos;
          acc += sq_dev(d) * (64'(model_right[c]) + model_left[c]);
        end
        v = acc / mass;
        r.var_q = (v > VAR_MAX) ? VAR_MAX : VAR_W'(v);
        r.mass = (mass > MASS_MAX) ? MASS_MAX : MASS_W'(mass);
      end
      for (int c = 0; c < NCELLS; c++) begin
        rr = model_right[c];
        ll = model_left[c];
        nr = (w * rr + (64'(WEIGHT_ONE) - w) * ll) >> WGT_SHIFT;
        nright[(c + 1) % NCELLS] = DENS_W'(nr);
        nleft[(c + NCELLS - 1) % NCELLS] = DENS_W'(rr + ll - nr);
      end
      for (int c = 0; c < NCELLS; c++) begin
        model_right[c] = nright[c];
        model_left[c] = nleft[c];
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        expected_results.push_back(predict_lattice({mode, cell_index, density}));
        items_sent++;
      end
      if (item_valid && item_stall) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        item_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 19) - 1;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_send) begin
        lattice_item_t it;
        it = pending_items.pop_front();
        item_valid <= 1'b1;
        mode <= it.mode;
        cell_index <= it.idx;
        density <= it.dens;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver idling
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          lattice_result_t e;
          e = expected_results.pop_front();
          if (cell_density !== e.dens_sum) begin
            $error("cell_density expected %0d actual %0d", e.dens_sum, cell_density);
            errors++;
          end
          if (total_mass !== e.mass) begin
            $error("total_mass expected %0d actual %0d", e.mass, total_mass);
            errors++;
          end
          if (variance !== e.var_q) begin
            $error("variance expected %0d actual %0d", e.var_q, variance);
            errors++;
          end
          if (empty_flag !== e.empty) begin
            $error("empty_flag expected %0d actual %0d", e.empty, empty_flag);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 19) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic add_item(logic [MODE_W-1:0] m, logic [IDX_W-1:0] i, logic [DENS_W-1:0] d);
    lattice_item_t it;
    it.mode = m;
    it.idx = i;
    it.dens = d;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic set_weight(logic [WGT_W-1:0] w);
    @(posedge clk);
    coll_weight_we <= 1'b1;
    coll_weight <= w;
    @(posedge clk);
    coll_weight_we <= 1'b0;
    model_weight = w;
  endtask

  task automatic random_phase(int n);
    int base;
    for (int k = 0; k < n; k++) begin
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 8) begin
        base = $urandom_range(0, 127);
        add_item(MODE_LOAD, IDX_W'(base),
                 ($urandom_range(0, 3) == 0) ? DENS_W'($urandom)
                                             : DENS_W'($urandom_range(0, 4095)));
      end else if (sel < 12) begin
        add_item(MODE_STEP, IDX_W'($urandom), DENS_W'($urandom));
      end else if (sel < 19) begin
        add_item(MODE_READ, IDX_W'($urandom), DENS_W'($urandom));
      end else begin
        add_item(MODE_NOP, IDX_W'($urandom), DENS_W'($urandom));
      end
    end
  endtask

  initial begin
    model_weight = WEIGHT_RST;
    for (int c = 0; c < NCELLS; c++) begin
      model_right[c] = '0;
      model_left[c] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (NCELLS + 10) @(posedge clk);

    // directed: empty ring, extremes, unused mode
    add_item(MODE_STEP, '0, '0);
    add_item(MODE_READ, 7'd127, '0);
    add_item(MODE_LOAD, 7'd0, {DENS_W{1'b1}});
    add_item(MODE_LOAD, 7'd127, {DENS_W{1'b1}});
    add_item(MODE_LOAD, 7'd64, 18'h15555);
    add_item(MODE_LOAD, 7'd63, 18'h2AAAA);
    add_item(MODE_READ, 7'd0, {DENS_W{1'b1}});
    add_item(MODE_NOP, 7'd127, {DENS_W{1'b1}});
    add_item(MODE_STEP, 7'd127, {DENS_W{1'b1}});
    add_item(MODE_STEP, '0, '0);
    add_item(MODE_READ, 7'd1, '0);
    add_item(MODE_READ, 7'd126, '0);
    drain();
    hold_send = 1'b0;

    begin
      logic [WGT_W-1:0] weights[6];
      weights = '{17'd0, WEIGHT_ONE, {WGT_W{1'b1}}, 17'd1, 17'd65535, WEIGHT_RST};
      for (int p = 0; p < 6; p++) begin
        set_weight(weights[p]);
        add_item(MODE_LOAD, 7'($urandom), DENS_W'($urandom));
        add_item(MODE_STEP, '0, '0);
        random_phase(300);
        if (p == 5) calm = 1'b1;
        drain();
      end
      set_weight(WGT_W'($urandom_range(0, 65536)));
      random_phase(150);
      drain();
    end
    $display("covered %0d items over seven collision weights incl. zero, one and above one",
             items_sent);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end
endmodule
